@@ hdl/iida_pkg.sv @@
package iida_pkg;

    // Default geometry of the array
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 64;

    // Interface field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 64;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Index width inside the cell row, wide enough for a count of 1024
    localparam int IDX_W = 11;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] key_word;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_word;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_count;
    } rsp_t;

    // Broadcast control for every cell of the row
    typedef struct packed {
        logic             ins;   // open a slot at lo, shift lo..hi-1 up
        logic             del;   // close the slot at lo, shift lo+1..hi down
        logic             wr;    // load key into the cell at lo
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } cell_ctrl_t;

endpackage

@@ hdl/iida_cell.sv @@
module iida_cell #(
    parameter int IDX       = 0,
    parameter int KEY_WIDTH = iida_pkg::KEY_WIDTH_DEF
) (
    input  logic                    clk,
    input  iida_pkg::cell_ctrl_t    ctrl,
    input  logic [KEY_WIDTH-1:0]    key,
    input  logic [KEY_WIDTH-1:0]    left_data,
    input  logic [KEY_WIDTH-1:0]    right_data,
    input  logic [iida_pkg::IDX_W-1:0] sel,
    output logic [KEY_WIDTH-1:0]    data,
    output logic [KEY_WIDTH-1:0]    rd_tap
);
    import iida_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [KEY_WIDTH-1:0] data_reg;
    logic [KEY_WIDTH-1:0] data_next;

    // Pick the new content: own key, left neighbor, right neighbor or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.wr && (MY_IDX == ctrl.lo))
        begin
            data_next = key;
        end
        else if (ctrl.ins)
        begin
            if (MY_IDX == ctrl.lo)
            begin
                data_next = key;
            end
            else if ((MY_IDX > ctrl.lo) && (MY_IDX <= ctrl.hi))
            begin
                data_next = left_data;
            end
        end
        else if (ctrl.del)
        begin
            if ((MY_IDX >= ctrl.lo) && (MY_IDX < ctrl.hi))
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign rd_tap = (sel == MY_IDX) ? data_reg : '0;

endmodule

@@ hdl/iida_row.sv @@
module iida_row #(
    parameter int DEPTH     = iida_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = iida_pkg::KEY_WIDTH_DEF
) (
    input  logic                       clk,
    input  iida_pkg::cell_ctrl_t       ctrl,
    input  logic [KEY_WIDTH-1:0]       key,
    input  logic [iida_pkg::IDX_W-1:0] sel,
    output logic [KEY_WIDTH-1:0]       rd_data
);
    import iida_pkg::*;

    logic [KEY_WIDTH-1:0] cell_data [DEPTH];
    logic [KEY_WIDTH-1:0] cell_tap  [DEPTH];

    // Chain the cells: each sees its left and right neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_w;
        logic [KEY_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_data[i+1];
        end

        iida_cell #(
            .IDX       (i),
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .key        (key),
            .left_data  (left_w),
            .right_data (right_w),
            .sel        (sel),
            .data       (cell_data[i]),
            .rd_tap     (cell_tap[i])
        );
    end

    // Merge the read taps; at most one cell matches sel
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_data = rd_data | cell_tap[i];
        end
    end

endmodule

@@ hdl/indexed_insert_delete_array_top.sv @@
// Ordered array of DEPTH key words held in a row of cells, one entry per
// cell, with a fill count. A request transfers at a clock edge where start
// is high and busy is low; busy stays low, so a new request can be issued
// every cycle. Each request yields exactly one response on rsp, marked by
// done for a single cycle, in the cycle after the transfer; the receiver has
// no way to hold it off and must take it then. Insert and remove shift the
// entries from the request position up to the fill count in parallel; a
// read selects its entry through the OR of the cell taps. Entries need no
// clearing after reset: only entries below the fill count are ever read back.
module indexed_insert_delete_array_top #(
    parameter int DEPTH     = iida_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = iida_pkg::KEY_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  iida_pkg::cmd_t cmd,
    output logic           done,
    output iida_pkg::rsp_t rsp
);
    import iida_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic             take;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] pos_ext;
    logic [IDX_W-1:0] cnt_ext;
    logic             full;
    logic [KEY_WIDTH-1:0] row_rd;

    assign busy    = 1'b0;
    assign take    = start && !busy;
    assign pos_ext = IDX_W'(cmd.position);
    assign cnt_ext = IDX_W'(count_reg);
    assign full    = (count_reg == FULL_CNT);

    // Decode the request into a row command and a response
    always_comb
    begin
        ctrl       = '0;
        count_next = count_reg;
        rsp_next   = '0;
        rsp_next.status = ST_DONE;
        if (take)
        begin
            case (op_t'(cmd.operation))
                OP_APPEND:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.wr    = 1'b1;
                        ctrl.lo    = cnt_ext;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_INSERT:
                begin
                    if (pos_ext > cnt_ext)
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                    else if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        ctrl.lo    = pos_ext;
                        ctrl.hi    = cnt_ext;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.del   = 1'b1;
                        ctrl.lo    = pos_ext;
                        ctrl.hi    = cnt_ext - 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                    else
                    begin
                        rsp_next.read_word = WORD_W'(row_rd);
                    end
                end
                OP_WRITE:
                begin
                    if (pos_ext >= cnt_ext)
                    begin
                        rsp_next.status = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.wr = 1'b1;
                        ctrl.lo = pos_ext;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_DONE;
                end
            endcase
        end
        rsp_next.fill_count = FILL_W'(count_next);
    end

    iida_row #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_row (
        .clk     (clk),
        .ctrl    (ctrl),
        .key     (cmd.key_word[KEY_WIDTH-1:0]),
        .sel     (pos_ext),
        .rd_data (row_rd)
    );

    // Advance the fill count and the response strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= take;
        end
    end

    // Hold the response payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ hdl/iida_check.sv @@
module iida_check #(
    parameter int DEPTH = iida_pkg::DEPTH_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input iida_pkg::cmd_t cmd,
    input logic           done,
    input iida_pkg::rsp_t rsp
);
    import iida_pkg::*;

    // Every transfer gets a response in the next cycle
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("no response after a request transfer");

    // No response without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("response without a request transfer");

    // A failed request returns a zero word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status != ST_DONE) |-> (rsp.read_word == '0))
        else $error("nonzero read word on a failed request");

    // Full status only when the array holds DEPTH entries
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == ST_FULL) |-> (rsp.fill_count == FILL_W'(DEPTH)))
        else $error("full status with a partial fill count");

endmodule

bind indexed_insert_delete_array_top iida_check #(
    .DEPTH (DEPTH)
) u_iida_check (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);
